@@ rtl/core/rubi_pkg.sv @@
// ----------------------------------------------------------------------------
// Ray/unit-box intersection package
// Shared constants and types for the slab-test pipeline.
// ----------------------------------------------------------------------------
package rubi_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int COORD_BITS_DEF = 8;
	localparam int VOX_W          = 8;
	localparam int FIX_W          = 32;
	localparam int DIST_W         = 31;
	localparam int S_TDATA_W      = 3 * VOX_W + 6 * FIX_W;
	localparam int M_TDATA_W      = 32;

	// Per-axis flags that travel beside the quotients through the divider.
	typedef struct packed {
		logic neg0;   // quotient for the lower plane (corner) is negative
		logic neg1;   // quotient for the upper plane (corner + 1) is negative
		logic dzero;  // direction is zero: axis does not bound t
		logic miss;   // zero direction and origin outside the slab
	} side_t;

endpackage

@@ rtl/core/rubi_div.sv @@
// ----------------------------------------------------------------------------
// Ray/unit-box pipelined divider
// Two unsigned restoring divisions by one shared divisor, one quotient bit
// per register stage.
// ----------------------------------------------------------------------------
module rubi_div #(
	parameter int QW = 49
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [31:0]           den,
	input  logic [QW-1:0]         num0,
	input  logic [QW-1:0]         num1,
	input  rubi_pkg::side_t       side_in,
	output logic [QW-1:0]         q0,
	output logic [QW-1:0]         q1,
	output logic                  rnz0,
	output logic                  rnz1,
	output rubi_pkg::side_t       side_out
);

	logic [31:0]     rem_s  [0:QW][0:1];
	logic [QW-1:0]   nq_s   [0:QW][0:1];
	logic [31:0]     den_s  [0:QW];
	rubi_pkg::side_t side_s [0:QW];

	assign rem_s[0][0] = '0;
	assign rem_s[0][1] = '0;
	assign nq_s[0][0]  = num0;
	assign nq_s[0][1]  = num1;
	assign den_s[0]    = den;
	assign side_s[0]   = side_in;

	for (genvar k = 0; k < QW; k++) begin : g_step
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [32:0] trial;
			logic [32:0] diff;
			logic        ge;

			assign trial = {rem_s[k][l], nq_s[k][l][QW-1]};
			assign diff  = trial - {1'b0, den_s[k]};
			assign ge    = trial >= {1'b0, den_s[k]};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1][l] <= ge ? diff[31:0] : trial[31:0];
					nq_s[k+1][l]  <= {nq_s[k][l][QW-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign q0       = nq_s[QW][0];
	assign q1       = nq_s[QW][1];
	assign rnz0     = |rem_s[QW][0];
	assign rnz1     = |rem_s[QW][1];
	assign side_out = side_s[QW];

endmodule

@@ rtl/core/ray_unit_box_intersection.sv @@
// ----------------------------------------------------------------------------
// Ray against unit voxel intersection
// Slab test of one ray against one unit cube per item, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one item per clock and returns one result per item, in
// order. The length of the pipeline is set mostly by the radix-2 divider,
// which settles one quotient bit per stage for all six plane parameters in
// parallel. The pipeline moves as a whole and an output skid stage takes a
// result while the previous one still waits, so a new item is accepted in
// every cycle unless both output slots are full.
// Each plane parameter is floor((plane - origin) * 2^FRAC_BITS / dir), with
// the y direction negated. An axis with zero direction misses when the origin
// lies outside its slab and otherwise places no bound. On a hit the distance
// is the entry parameter if positive, else the exit parameter, saturated to
// 31 bits; on a miss hit and distance are both zero.
module ray_unit_box_intersection #(
	parameter int FRAC_BITS  = rubi_pkg::FRAC_BITS_DEF,
	parameter int COORD_BITS = rubi_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// voxel_x, voxel_y, voxel_z (8 each), origin_x, origin_y, origin_z,
	// direction_x, direction_y, direction_z (32 each), from bit 0 up
	input  logic [rubi_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// distance (31), one zero pad bit
	output logic [rubi_pkg::M_TDATA_W-1:0] m_tdata,
	// hit
	output logic                           m_tuser
);

	localparam int PW     = COORD_BITS + FRAC_BITS + 1;
	localparam int DIFF_W = ((PW > rubi_pkg::FIX_W) ? PW : rubi_pkg::FIX_W) + 1;
	localparam int QW     = DIFF_W + FRAC_BITS;
	localparam int TW     = QW + 1;
	localparam int VW     = rubi_pkg::VOX_W;
	localparam int FW     = rubi_pkg::FIX_W;
	// Corner bits actually taken from a voxel field.
	localparam int CW     = (COORD_BITS < VW) ? COORD_BITS : VW;

	logic adv;
	logic skid_v_q;
	assign adv      = !skid_v_q;
	assign s_tready = adv;

	// Stage 1: plane minus origin for both planes of each axis.
	logic              v_s1;
	logic [DIFF_W-1:0] diff_s1 [3][2];
	logic [FW-1:0]     dir_s1  [3];

	for (genvar a = 0; a < 3; a++) begin : g_s1
		logic [CW-1:0] corner;
		logic [PW-1:0] p0;
		logic [PW-1:0] p1;
		logic [FW-1:0] org;

		assign corner = s_tdata[a*VW +: CW];
		assign org    = s_tdata[3*VW + a*FW +: FW];
		assign p0     = {{(PW-CW-FRAC_BITS){1'b0}}, corner, {FRAC_BITS{1'b0}}};
		assign p1     = p0 + {{(PW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

		always_ff @(posedge clk) begin
			if (adv) begin
				diff_s1[a][0] <= {{(DIFF_W-PW){1'b0}}, p0}
					- {{(DIFF_W-FW){org[FW-1]}}, org};
				diff_s1[a][1] <= {{(DIFF_W-PW){1'b0}}, p1}
					- {{(DIFF_W-FW){org[FW-1]}}, org};
				dir_s1[a]     <= s_tdata[3*VW + (3+a)*FW +: FW];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	// Stage 2: magnitudes and signs for the unsigned divider.
	logic              v_s2;
	logic [QW-1:0]     num_s2  [3][2];
	logic [31:0]       den_s2  [3];
	rubi_pkg::side_t   side_s2 [3];

	for (genvar a = 0; a < 3; a++) begin : g_s2
		logic          dneg;
		logic          nneg0;
		logic          nneg1;
		logic          dzero;
		logic          out_lo;
		logic          out_hi;

		assign nneg0  = diff_s1[a][0][DIFF_W-1];
		assign nneg1  = diff_s1[a][1][DIFF_W-1];
		assign dzero  = dir_s1[a] == '0;
		// The y direction enters negated; its magnitude is unchanged.
		assign dneg   = dir_s1[a][FW-1] ^ (a == 1);
		assign out_lo = !nneg0 && (diff_s1[a][0] != '0);
		assign out_hi = nneg1;

		always_ff @(posedge clk) begin
			if (adv) begin
				num_s2[a][0] <= {(nneg0 ? -diff_s1[a][0] : diff_s1[a][0]),
					{FRAC_BITS{1'b0}}};
				num_s2[a][1] <= {(nneg1 ? -diff_s1[a][1] : diff_s1[a][1]),
					{FRAC_BITS{1'b0}}};
				den_s2[a]    <= dir_s1[a][FW-1] ? -dir_s1[a] : dir_s1[a];
				side_s2[a]   <= '{neg0: nneg0 ^ dneg, neg1: nneg1 ^ dneg,
					dzero: dzero, miss: dzero && (out_lo || out_hi)};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	// Divider stages: valid bits ride alongside the quotient pipeline.
	logic [QW-1:0]   q_dv    [3][2];
	logic            rnz_dv  [3][2];
	rubi_pkg::side_t side_dv [3];
	logic [QW-1:0]   v_dv_s3;

	for (genvar a = 0; a < 3; a++) begin : g_div
		rubi_div #(.QW(QW)) u_div (
			.clk      (clk),
			.en       (adv),
			.den      (den_s2[a]),
			.num0     (num_s2[a][0]),
			.num1     (num_s2[a][1]),
			.side_in  (side_s2[a]),
			.q0       (q_dv[a][0]),
			.q1       (q_dv[a][1]),
			.rnz0     (rnz_dv[a][0]),
			.rnz1     (rnz_dv[a][1]),
			.side_out (side_dv[a])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_dv_s3 <= '0;
		end else if (adv) begin
			v_dv_s3 <= {v_dv_s3[QW-2:0], v_s2};
		end
	end

	// Stage A: signed floor quotient. A negative inexact quotient is -q-1.
	logic            v_sa;
	logic [TW-1:0]   t_sa    [3][2];
	rubi_pkg::side_t side_sa [3];

	for (genvar a = 0; a < 3; a++) begin : g_sa
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [TW-1:0] qx;
			logic          neg;
			assign qx  = {1'b0, q_dv[a][l]};
			assign neg = (l == 0) ? side_dv[a].neg0 : side_dv[a].neg1;
			always_ff @(posedge clk) begin
				if (adv) begin
					t_sa[a][l] <= !neg ? qx : (rnz_dv[a][l] ? ~qx : -qx);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				side_sa[a] <= side_dv[a];
			end
		end
	end

	// Stage B: entry and exit parameter per axis.
	logic          v_sb;
	logic [TW-1:0] tn_sb [3];
	logic [TW-1:0] tf_sb [3];
	logic [2:0]    dz_sb;
	logic          miss_sb;

	for (genvar a = 0; a < 3; a++) begin : g_sb
		logic lt;
		assign lt = $signed(t_sa[a][0]) < $signed(t_sa[a][1]);
		always_ff @(posedge clk) begin
			if (adv) begin
				tn_sb[a] <= lt ? t_sa[a][0] : t_sa[a][1];
				tf_sb[a] <= lt ? t_sa[a][1] : t_sa[a][0];
				dz_sb[a] <= side_sa[a].dzero;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_sb <= side_sa[0].miss || side_sa[1].miss || side_sa[2].miss;
		end
	end

	// Stage C: largest entry and smallest exit over the bounding axes.
	logic          v_sc;
	logic [TW-1:0] lo_sc;
	logic [TW-1:0] hi_sc;
	logic          lo_inf_sc;
	logic          hi_inf_sc;
	logic          miss_sc;

	always_ff @(posedge clk) begin
		logic [TW-1:0] lo;
		logic [TW-1:0] hi;
		logic          inf;
		if (adv) begin
			lo  = '0;
			hi  = '0;
			inf = 1'b1;
			for (int a = 0; a < 3; a++) begin
				if (!dz_sb[a]) begin
					if (inf || $signed(tn_sb[a]) > $signed(lo)) begin
						lo = tn_sb[a];
					end
					if (inf || $signed(tf_sb[a]) < $signed(hi)) begin
						hi = tf_sb[a];
					end
					inf = 1'b0;
				end
			end
			lo_sc     <= lo;
			hi_sc     <= hi;
			lo_inf_sc <= inf;
			hi_inf_sc <= inf;
			miss_sc   <= miss_sb;
		end
	end

	// Stage D: hit decision and saturated distance.
	logic                       v_sd;
	logic                       hit_sd;
	logic [rubi_pkg::DIST_W-1:0] dist_sd;

	logic                       hit_c;
	logic [TW-1:0]              pick_c;
	logic                       pick_inf_c;
	logic [rubi_pkg::DIST_W-1:0] dist_c;
	logic [TW-1:0]              dmax_c;

	assign dmax_c = {{(TW-rubi_pkg::DIST_W){1'b0}}, {rubi_pkg::DIST_W{1'b1}}};

	always_comb begin
		hit_c = !miss_sc && (hi_inf_sc || !hi_sc[TW-1])
			&& (lo_inf_sc || hi_inf_sc || $signed(lo_sc) <= $signed(hi_sc));
		if (!lo_inf_sc && $signed(lo_sc) > 0) begin
			pick_c     = lo_sc;
			pick_inf_c = 1'b0;
		end else begin
			pick_c     = hi_sc;
			pick_inf_c = hi_inf_sc;
		end
		if (!hit_c) begin
			dist_c = '0;
		end else if (pick_inf_c || $signed(pick_c) > $signed(dmax_c)) begin
			dist_c = '1;
		end else if (pick_c[TW-1]) begin
			dist_c = '0;
		end else begin
			dist_c = pick_c[rubi_pkg::DIST_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_sd  <= hit_c;
			dist_sd <= dist_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa <= 1'b0;
			v_sb <= 1'b0;
			v_sc <= 1'b0;
			v_sd <= 1'b0;
		end else if (adv) begin
			v_sa <= v_dv_s3[QW-1];
			v_sb <= v_sa;
			v_sc <= v_sb;
			v_sd <= v_sc;
		end
	end

	// Output register with a skid slot behind it.
	logic                        emerge;
	logic                        out_v_q;
	logic                        out_hit_q;
	logic [rubi_pkg::DIST_W-1:0] out_dist_q;
	logic                        skid_hit_q;
	logic [rubi_pkg::DIST_W-1:0] skid_dist_q;

	assign emerge = adv && v_sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q  <= emerge;
			end
		end else if (emerge) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_hit_q  <= skid_hit_q;
				out_dist_q <= skid_dist_q;
			end else begin
				out_hit_q  <= hit_sd;
				out_dist_q <= dist_sd;
			end
		end else if (emerge) begin
			skid_hit_q  <= hit_sd;
			skid_dist_q <= dist_sd;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_hit_q;
	assign m_tdata  = {{(rubi_pkg::M_TDATA_W-rubi_pkg::DIST_W){1'b0}}, out_dist_q};

endmodule

@@ rtl/core/rubi_checker.sv @@
// ----------------------------------------------------------------------------
// Ray/unit-box result checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rubi_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [rubi_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tuser
);

	// A miss always reports a zero distance.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss with nonzero distance");

	// The pad bit above the distance stays clear.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[rubi_pkg::M_TDATA_W-1])
		else $error("pad bit set");

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

bind ray_unit_box_intersection rubi_checker u_rubi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ sim/ray_unit_box_intersection_tb.sv @@
// ----------------------------------------------------------------------------
// Ray/unit-box intersection testbench
// Sends rays against unit voxels through the stream ports, predicts the hit
// flag and distance of every item with an independent slab test and checks
// each result in order, under random idling and a long output stall.
// ----------------------------------------------------------------------------
module ray_unit_box_intersection_tb;

	localparam int FRAC     = rubi_pkg::FRAC_BITS_DEF;
	localparam int COORD    = rubi_pkg::COORD_BITS_DEF;
	localparam int LATENCY  = FRAC + ((COORD + FRAC + 1) > 32 ? (COORD + FRAC + 1) : 32) + 7;
	localparam int MAX_CYC  = 400000;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	localparam longint DIST_SAT = 64'h7FFF_FFFF;

	typedef struct {
		logic [7:0]         vx, vy, vz;
		logic signed [31:0] ox, oy, oz;
		logic signed [31:0] dx, dy, dz;
	} ray_t;

	typedef struct {
		logic        hit;
		logic [30:0] distance;
	} hit_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [rubi_pkg::S_TDATA_W-1:0] s_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [rubi_pkg::M_TDATA_W-1:0] m_tdata;
	logic                           m_tuser;

	hit_t   pending_hits[$];
	int     errors;
	int     rays_sent;
	int     results_seen;
	int     hits_seen;
	int     cycle_count;
	bit     quiet;          // no idling on either side while set
	int     stall_request;  // receiver hold-off length, picked up by the receiver
	int     stall_left;

	ray_unit_box_intersection dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Floor division, rounding toward minus infinity as the block does.
	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && ((a < 0) != (b < 0)))
			q = q - 1;
		return q;
	endfunction

	// Narrows the parameter interval [lo, hi] by one axis slab. A zero
	// direction only decides whether the origin sits inside the slab.
	function automatic void clip_slab(input logic [7:0] corner, input longint org,
			input longint dir, inout longint lo, inout longint hi, inout bit in_slab);
		longint unit, p0, p1, t0, t1;
		unit = longint'(1) <<< FRAC;
		p0 = longint'(corner & ((1 << COORD) - 1)) * unit;
		p1 = p0 + unit;
		if (dir == 0) begin
			if (org < p0 || org > p1)
				in_slab = 1'b0;
			return;
		end
		t0 = floor_quot((p0 - org) * unit, dir);
		t1 = floor_quot((p1 - org) * unit, dir);
		if ((t0 < t1 ? t0 : t1) > lo)
			lo = t0 < t1 ? t0 : t1;
		if ((t0 < t1 ? t1 : t0) < hi)
			hi = t0 < t1 ? t1 : t0;
	endfunction

	function automatic hit_t slab_hit(ray_t r);
		longint lo, hi, dist_v;
		bit     in_slab;
		hit_t   h;
		lo = 64'sh8000_0000_0000_0000;
		hi = 64'sh7FFF_FFFF_FFFF_FFFF;
		in_slab = 1'b1;
		clip_slab(r.vx, longint'(r.ox), longint'(r.dx), lo, hi, in_slab);
		// The y axis runs against the negated direction.
		clip_slab(r.vy, longint'(r.oy), -longint'(r.dy), lo, hi, in_slab);
		clip_slab(r.vz, longint'(r.oz), longint'(r.dz), lo, hi, in_slab);
		h.hit = 1'b0;
		h.distance = '0;
		if (!in_slab || hi < 0 || lo > hi)
			return h;
		dist_v = lo > 0 ? lo : hi;
		if (dist_v > DIST_SAT)
			dist_v = DIST_SAT;
		if (dist_v < 0)
			dist_v = 0;
		h.hit = 1'b1;
		h.distance = dist_v[30:0];
		return h;
	endfunction

	function automatic ray_t make_ray(logic [7:0] vx, vy, vz,
			logic signed [31:0] ox, oy, oz, dx, dy, dz);
		ray_t r;
		r.vx = vx; r.vy = vy; r.vz = vz;
		r.ox = ox; r.oy = oy; r.oz = oz;
		r.dx = dx; r.dy = dy; r.dz = dz;
		return r;
	endfunction

	// Offers one ray, optionally after a random idle gap, and files its
	// expected result once the block has taken it. Valid stays high after
	// acceptance so back-to-back items need no extra edge.
	task automatic send_ray(ray_t r);
		while (!quiet && $urandom_range(99) < 10) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r.dz, r.dy, r.dx, r.oz, r.oy, r.ox, r.vz, r.vy, r.vx};
		do
			@(posedge clk);
		while (!s_tready);
		pending_hits.push_back(slab_hit(r));
		rays_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
	endtask

	// A ray aimed from near the voxel at its center, so most of these hit.
	function automatic ray_t aimed_ray();
		ray_t r;
		logic signed [31:0] cx, cy, cz;
		r.vx = 8'($urandom); r.vy = 8'($urandom); r.vz = 8'($urandom);
		cx = (32'(r.vx) << 16) + 32'h8000;
		cy = (32'(r.vy) << 16) + 32'h8000;
		cz = (32'(r.vz) << 16) + 32'h8000;
		r.ox = cx + ((int'($urandom_range(16)) - 8) <<< 16) + int'($urandom_range(16'hFFFF)) - 32'h8000;
		r.oy = cy + ((int'($urandom_range(16)) - 8) <<< 16) + int'($urandom_range(16'hFFFF)) - 32'h8000;
		r.oz = cz + ((int'($urandom_range(16)) - 8) <<< 16) + int'($urandom_range(16'hFFFF)) - 32'h8000;
		r.dx = (cx - r.ox) + int'($urandom_range(16'h3FFF)) - 32'h2000;
		r.dy = -((cy - r.oy) + int'($urandom_range(16'h3FFF)) - 32'h2000);
		r.dz = (cz - r.oz) + int'($urandom_range(16'h3FFF)) - 32'h2000;
		// Scale the direction so the hit distance spreads out.
		case ($urandom_range(3))
			0: begin r.dx = r.dx >>> 4; r.dy = r.dy >>> 4; r.dz = r.dz >>> 4; end
			1: begin r.dx = r.dx <<< 3; r.dy = r.dy <<< 3; r.dz = r.dz <<< 3; end
			default: ;
		endcase
		// Axis-parallel rays now and then.
		if ($urandom_range(7) == 0) r.dx = 0;
		if ($urandom_range(7) == 0) r.dy = 0;
		if ($urandom_range(7) == 0) r.dz = 0;
		return r;
	endfunction

	function automatic ray_t noise_ray();
		ray_t r;
		r = make_ray(8'($urandom), 8'($urandom), 8'($urandom), $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom);
		if ($urandom_range(3) == 0) r.dx = 0;
		if ($urandom_range(3) == 0) r.dy = 0;
		if ($urandom_range(3) == 0) r.dz = 0;
		return r;
	endfunction

	task automatic test_corner_cases();
		// All directions zero with the origin on the corner: unbounded hit.
		send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0));
		// Straight along +x into voxel 0.
		send_ray(make_ray(0, 0, 0, -2 * ONE, 32'h8000, 32'h8000, ONE, 0, 0));
		// Parallel on y but outside the slab: miss.
		send_ray(make_ray(0, 0, 0, -2 * ONE, 2 * ONE + 1, 32'h8000, ONE, 0, 0));
		// Parallel, origin on the far plane: still inside.
		send_ray(make_ray(0, 0, 0, -2 * ONE, ONE, ONE, ONE, 0, 0));
		// Negative y direction moves toward +y after the negation: hit.
		send_ray(make_ray(0, 5, 0, 32'h8000, 32'h8000, 32'h8000, 0, -ONE, 0));
		// Positive y direction moves away: miss.
		send_ray(make_ray(0, 5, 0, 32'h8000, 32'h8000, 32'h8000, 0, ONE, 0));
		// Exit parameter exactly zero: hit at distance zero.
		send_ray(make_ray(0, 0, 0, ONE, 32'h8000, 32'h8000, ONE, 0, 0));
		// Tiny positive entry that floors to zero: the exit is reported.
		send_ray(make_ray(0, 0, 0, -1, 32'h8000, 32'h8000, 32'h7FFF_FFFF, 0, 0));
		// Distance far beyond 31 bits saturates.
		send_ray(make_ray(0, 0, 0, 32'h8000_0000, 32'h8000, 32'h8000, 1, 0, 0));
		// Origin inside, diagonal: entry negative, exit reported.
		send_ray(make_ray(9, 9, 9, 9 * ONE + 32'h4000, 9 * ONE + 32'h4000,
			9 * ONE + 32'h4000, ONE, ONE, ONE));
		// Highest voxel approached along -z.
		send_ray(make_ray(255, 255, 255, 255 * ONE + 32'h8000, 255 * ONE + 32'h8000,
			32'h7FFF_FFFF, 0, 0, -ONE));
		// Field extremes.
		send_ray(make_ray(255, 255, 255, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		send_ray(make_ray(255, 0, 255, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
		send_ray(make_ray(0, 255, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_ray(make_ray(128, 128, 128, 128 * ONE, 128 * ONE, 128 * ONE,
			-1, 1, -1));
		send_ray(make_ray(7, 7, 7, 7 * ONE, 7 * ONE, 7 * ONE, 0, 0, 0));
		send_ray(make_ray(7, 7, 7, 7 * ONE - 1, 7 * ONE, 7 * ONE, 0, 0, 0));
		send_ray(make_ray(3, 3, 3, 0, 0, 0, 32'h0000_0001, -32'sh0000_0001, 32'h0000_0001));
	endtask

	task automatic test_random_rays(int count);
		repeat (count)
			send_ray($urandom_range(99) < 75 ? aimed_ray() : noise_ray());
	endtask

	// The receiver holds off while rays keep coming, so the pipeline fills and
	// input ready must drop; then the sender waits for every result.
	task automatic test_output_stall();
		stall_request = 4 * LATENCY;
		test_random_rays(150);
		drain_results();
	endtask

	// Receiver: random idling, plus long hold-offs on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (stall_request > 0) begin
			stall_left    <= stall_request;
			stall_request  = 0;
			m_tready      <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(99) >= 10);
		end
	end

	// Compares every accepted result with the oldest prediction.
	always @(posedge clk) begin
		hit_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_hits.size() == 0) begin
				$error("result with no ray outstanding: hit=%0b distance=%0h",
					m_tuser, m_tdata[30:0]);
				errors++;
			end else begin
				want = pending_hits.pop_front();
				if (m_tuser) hits_seen++;
				if (m_tuser !== want.hit) begin
					$error("hit: expected %0b, got %0b", want.hit, m_tuser);
					errors++;
				end
				if (m_tdata[30:0] !== want.distance) begin
					$error("distance: expected %0h, got %0h", want.distance, m_tdata[30:0]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYC) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		errors = 0;
		rays_sent = 0;
		results_seen = 0;
		hits_seen = 0;
		cycle_count = 0;
		quiet = 1'b0;
		stall_request = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_random_rays(150);
		quiet = 1'b1;
		test_random_rays(100);
		quiet = 1'b0;
		test_output_stall();
		test_random_rays(100);

		drain_results();
		repeat (LATENCY + 20) @(posedge clk);
		$display("Sent %0d rays (corner cases, aimed and random), checked %0d results, %0d hits,",
			rays_sent, results_seen, hits_seen);
		$display("with random idling, a no-idle stretch and a long output stall.");
		if (errors == 0 && pending_hits.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
